>>> hw/rtl/serial_frame_checker_assert.svh
// Assertion macros used by the serial frame checker port assertions.
`ifndef SERIAL_FRAME_CHECKER_ASSERT_SVH
`define SERIAL_FRAME_CHECKER_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define SFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked at the next clock edge.
`define SFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sfc_pkg.sv
// Types and constants shared by the serial frame checker modules.
`default_nettype none

package sfc_pkg;

  localparam logic [7:0] CH_U  = 8'h55;
  localparam logic [7:0] CH_V  = 8'h56;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_T  = 8'h54;

  localparam logic [7:0] LONG_LIMIT_RESET = 8'd100;
  localparam logic [7:0] MIN_LENGTH_RESET = 8'd8;
  localparam logic [7:0] COUNT_MAX        = 8'd255;

  // Configuration register indexes.
  localparam logic REG_LONG_LIMIT = 1'b0;
  localparam logic REG_MIN_LENGTH = 1'b1;

  // Input kinds carried on the slave-side tuser.
  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TIMEOUT = 3'd1,
    ST_SHORT   = 3'd2,
    ST_HEADER  = 3'd3,
    ST_LENGTH  = 3'd4
  } sfc_status_e;

  typedef struct packed {
    logic [2:0][7:0] hist;      // index 0 is the newest byte
    logic [7:0]      count;
    logic [7:0]      first;
    logic [7:0]      second;
    logic [7:0]      decl;
  } sfc_state_t;

  typedef struct packed {
    logic [7:0]  echo;
    logic        frame_end;
    sfc_status_e status;
    logic [7:0]  length;
  } sfc_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/sfc_step.sv
// Per-beat frame tracking: next frame state and the result for one input beat.
`default_nettype none

module sfc_step (
  input  sfc_pkg::sfc_state_t  state_i,
  input  logic                 action_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [7:0]           long_limit_i,
  input  logic [7:0]           min_length_i,
  output sfc_pkg::sfc_state_t  state_o,
  output sfc_pkg::sfc_result_t result_o
);
  import sfc_pkg::*;

  sfc_state_t cur;
  logic [7:0] cnt_new;
  logic       trailer;
  logic       ends;

  always_comb begin
    // A new frame starts from a clean history and clean header bytes.
    cur = state_i;
    if (state_i.count == 8'd0) begin
      cur.hist   = '0;
      cur.first  = '0;
      cur.second = '0;
      cur.decl   = '0;
    end

    if (state_i.count == 8'd0) begin
      cur.first = rx_byte_i;
    end
    if (state_i.count == 8'd1) begin
      cur.second = rx_byte_i;
    end
    if (state_i.count == 8'd2) begin
      cur.decl = rx_byte_i;
    end

    cnt_new = (state_i.count == COUNT_MAX) ? COUNT_MAX : state_i.count + 8'd1;

    trailer = (cur.hist[2] == CH_U) && (cur.hist[1] == CH_V) &&
              (cur.hist[0] == CH_CR) && (rx_byte_i == CH_LF);
    ends    = trailer || ((rx_byte_i == CH_LF) && (cnt_new >= long_limit_i));

    state_o            = cur;
    state_o.count      = cnt_new;
    result_o.echo      = rx_byte_i;
    result_o.frame_end = ends;
    result_o.length    = cnt_new;
    result_o.status    = ST_OK;

    if (ends) begin
      state_o.count = 8'd0;
      priority if (cnt_new < min_length_i) begin
        result_o.status = ST_SHORT;
      end else if ((cur.first != CH_S) || (cur.second != CH_T)) begin
        result_o.status = ST_HEADER;
      end else if (cur.decl != cnt_new) begin
        result_o.status = ST_LENGTH;
      end else begin
        result_o.status = ST_OK;
      end
    end else begin
      state_o.hist = {cur.hist[1], cur.hist[0], rx_byte_i};
    end

    // A timeout aborts the open frame and leaves everything else alone.
    if (action_i == ACT_TIMEOUT) begin
      state_o            = state_i;
      state_o.count      = 8'd0;
      result_o.echo      = 8'd0;
      result_o.frame_end = 1'b1;
      result_o.status    = ST_TIMEOUT;
      result_o.length    = state_i.count;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/serial_frame_checker.sv
// Top level of the serial frame checker: beat registers, frame state and config.
`default_nettype none

// Serial frame checker. Each slave beat is either a received byte (tuser 0)
// or a receive idle timeout (tuser 1), and each one yields exactly one
// master beat: the byte echoed back, tlast set when the beat closes a frame,
// the frame status in tuser and the running frame length. A frame closes on
// the trailer U V CR LF, or on a bare LF once the length has reached the
// long_limit register; the closing beat carries the verdict (too short,
// bad header 'S' 'T', third byte not equal to the length, or ok, checked in
// that order). A timeout aborts the open frame and reports its length so
// far. The block takes one beat per cycle unless the master side stalls. A
// beat taken on the slave side is held in the input register, passes through
// the step logic and then sits in the result register, offered on the master
// side until taken. The frame state is updated once per beat in the step
// logic between those two registers. The configuration port writes
// long_limit (index 0) and min_length (index 1) and should only be used
// while no beat is in flight.
module serial_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave side.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] action
  // Master side.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] echo_byte, [15:8] frame_length
  output logic        m_axis_tlast,   // frame_end
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import sfc_pkg::*;

  logic        in_valid_q;
  logic        in_action_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  sfc_result_t out_result_q;
  sfc_state_t  state_q;
  sfc_state_t  state_d;
  sfc_result_t result_d;
  logic [7:0]  long_limit_q;
  logic [7:0]  min_length_q;
  logic        advance;

  // The held beat moves on whenever the result register is free or drains.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  sfc_step u_step (
    .state_i      (state_q),
    .action_i     (in_action_q),
    .rx_byte_i    (in_byte_q),
    .long_limit_i (long_limit_q),
    .min_length_i (min_length_q),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      state_q      <= '0;
      long_limit_q <= LONG_LIMIT_RESET;
      min_length_q <= MIN_LENGTH_RESET;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_LONG_LIMIT: long_limit_q <= cfg_data_i;
          REG_MIN_LENGTH: min_length_q <= cfg_data_i;
          default:        long_limit_q <= long_limit_q;
        endcase
      end
    end
  end

  // Payload registers load with their handshake and need no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_action_q <= s_axis_tuser;
      in_byte_q   <= s_axis_tdata;
    end
    if (advance) begin
      out_result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_result_q.length, out_result_q.echo};
  assign m_axis_tlast  = out_result_q.frame_end;
  assign m_axis_tuser  = out_result_q.status;

endmodule

`default_nettype wire

>>> hw/rtl/sfc_checker.sv
// Port-level assertions for the serial frame checker and their bind.
`default_nettype none

`include "serial_frame_checker_assert.svh"

module sfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [2:0]  m_axis_tuser
);
  import sfc_pkg::*;

  `SFC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "master beat dropped while stalled")

  `SFC_ASSERT_IMPLY(a_mid_frame_ok, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, (m_axis_tuser == ST_OK) && (m_axis_tdata[15:8] != 8'd0), "mid-frame beat with status or zero length")

  `SFC_ASSERT_IMPLY(a_timeout_shape, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == ST_TIMEOUT), m_axis_tlast && (m_axis_tdata[7:0] == 8'd0), "timeout beat not closing or not zero")

  `SFC_ASSERT_IMPLY(a_close_on_lf, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast && (m_axis_tuser != ST_TIMEOUT), m_axis_tdata[7:0] == CH_LF, "frame closed on a byte other than LF")

endmodule

bind serial_frame_checker sfc_checker u_sfc_checker (.*);

`default_nettype wire

>>> test/tb_serial_frame_checker.sv
// Self-checking testbench for the serial frame checker stream block.
`timescale 1ns / 100ps

module tb_serial_frame_checker;
  import sfc_pkg::*;

  localparam int STALL_LIMIT = 2000;   // cycles without any beat before giving up
  localparam int PHASE_ITEMS = 125;    // random items per configuration phase
  localparam int TAIL_CYCLES = 8;      // pipeline is two deep, leave some margin

  typedef struct {
    logic       act;
    logic [7:0] data;
  } rx_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;
  logic        s_user = ACT_BYTE;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;
  logic        m_last;
  logic [2:0]  m_user;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_LONG_LIMIT;
  logic [7:0]  cfg_data = '0;

  serial_frame_checker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last),
    .m_axis_tuser  (m_user),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Items waiting to be driven, and the results expected back, oldest first.
  rx_item_t    rx_queue[$];
  sfc_result_t expected_echoes[$];
  rx_item_t    next_item;

  // Mirror of the block's frame state and registers.
  sfc_state_t  frame_now;
  logic [7:0]  limit_now;
  logic [7:0]  min_len_now;

  int          fail_count = 0;
  int          items_made = 0;
  int          idle_mode = 0;     // 0: light gaps, heavy stalls; 1: reverse; 2: none
  int          quiet_cycles = 0;

  // Advance the mirrored frame state by one beat and return the result it yields.
  function automatic sfc_result_t frame_step(input logic act, input logic [7:0] b);
    sfc_result_t r;
    logic        closes;
    r = '0;
    if (act == ACT_TIMEOUT) begin
      // A timeout aborts whatever frame is open and reports its length so far.
      r.frame_end = 1'b1;
      r.status = ST_TIMEOUT;
      r.length = frame_now.count;
      frame_now.count = '0;
      return r;
    end
    if (frame_now.count == 8'd0) begin
      frame_now.hist = '0;
      frame_now.first = '0;
      frame_now.second = '0;
      frame_now.decl = '0;
    end
    case (frame_now.count)
      8'd0: frame_now.first = b;
      8'd1: frame_now.second = b;
      8'd2: frame_now.decl = b;
      default: ;
    endcase
    if (frame_now.count != COUNT_MAX) frame_now.count = frame_now.count + 8'd1;
    closes = (frame_now.hist[2] == CH_U && frame_now.hist[1] == CH_V &&
              frame_now.hist[0] == CH_CR && b == CH_LF) ||
             (b == CH_LF && frame_now.count >= limit_now);
    r.echo = b;
    r.frame_end = closes;
    r.length = frame_now.count;
    r.status = ST_OK;
    if (closes) begin
      // Verdicts are checked in priority order: length, header, declared length.
      if (frame_now.count < min_len_now) r.status = ST_SHORT;
      else if (frame_now.first != CH_S || frame_now.second != CH_T) r.status = ST_HEADER;
      else if (frame_now.decl != frame_now.count) r.status = ST_LENGTH;
      frame_now.count = '0;
    end else begin
      frame_now.hist = {frame_now.hist[1:0], b};
    end
    return r;
  endfunction

  function automatic bit sender_pauses();
    case (idle_mode)
      0: return $urandom_range(0, 99) < 16;
      1: return $urandom_range(0, 99) < 62;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      0: return $urandom_range(0, 99) < 62;
      1: return $urandom_range(0, 99) < 16;
      default: return 1'b0;
    endcase
  endfunction

  // Any random byte except LF, so a frame body never closes early on its own.
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CH_LF) ? CH_U : b;
  endfunction

  task automatic push_item(input logic act, input logic [7:0] data);
    rx_item_t it;
    it.act = act;
    it.data = data;
    rx_queue.push_back(it);
    items_made++;
  endtask

  // Header bytes, a body, then the U V CR LF trailer.
  task automatic push_closed_frame(input logic [7:0] h1, input logic [7:0] h2,
                                   input logic [7:0] decl, input int body_len,
                                   input bit random_body, input logic [7:0] fill);
    push_item(ACT_BYTE, h1);
    push_item(ACT_BYTE, h2);
    push_item(ACT_BYTE, decl);
    repeat (body_len) push_item(ACT_BYTE, random_body ? body_byte() : fill);
    push_item(ACT_BYTE, CH_U);
    push_item(ACT_BYTE, CH_V);
    push_item(ACT_BYTE, CH_CR);
    push_item(ACT_BYTE, CH_LF);
  endtask

  // One run of random stimulus: mostly well-formed frames with random content,
  // plus bare-LF frames, aborted frames and noise.
  task automatic make_random_run();
    logic [7:0] marks [6];
    int         pick;
    int         n;
    logic [7:0] h1;
    logic [7:0] h2;
    logic [7:0] decl;
    marks = '{CH_U, CH_V, CH_CR, CH_LF, CH_S, CH_T};
    pick = $urandom_range(0, 99);
    h1 = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CH_S;
    h2 = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CH_T;
    if (pick < 62) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 24);
      decl = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'(n + 7);
      push_closed_frame(h1, h2, decl, n, 1'b1, 8'h00);
    end else if (pick < 62 + ((limit_now <= 40) ? 18 : 3)) begin
      // Overlong frame closed by a bare LF once the length limit is reached.
      n = limit_now + $urandom_range(0, 2);
      decl = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'(n);
      for (int i = 0; i < n - 1; i++) begin
        push_item(ACT_BYTE, (i == 0) ? h1 : (i == 1) ? h2 : (i == 2) ? decl : body_byte());
      end
      push_item(ACT_BYTE, CH_LF);
    end else if (pick < 90) begin
      // Frame cut off by a receive timeout.
      push_item(ACT_BYTE, h1);
      repeat ($urandom_range(0, 6)) push_item(ACT_BYTE, body_byte());
      push_item(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 4) == 0) push_item(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 1) == 0) push_item(ACT_BYTE, marks[$urandom_range(0, 5)]);
        else push_item(ACT_BYTE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic write_reg(input logic index, input logic [7:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    if (index == REG_LONG_LIMIT) limit_now = value;
    else min_len_now = value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued item has been taken and every result has come back.
  task automatic drain();
    while (rx_queue.size() != 0 || s_valid || expected_echoes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Driver: predict each accepted beat, then offer the next pending item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data <= '0;
      s_user <= ACT_BYTE;
    end else begin
      if (s_valid && s_ready) expected_echoes.push_back(frame_step(s_user, s_data));
      if (!s_valid || s_ready) begin
        if (rx_queue.size() != 0 && !sender_pauses()) begin
          next_item = rx_queue.pop_front();
          s_valid <= 1'b1;
          s_data <= next_item.data;
          s_user <= next_item.act;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        if (expected_echoes.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result beat with nothing expected: echo %02h last %b status %0d len %0d",
                     $time, m_data[7:0], m_last, m_user, m_data[15:8]);
          end
        end else begin
          sfc_result_t want;
          want = expected_echoes.pop_front();
          if (m_data[7:0] != want.echo || m_last != want.frame_end ||
              m_user != want.status || m_data[15:8] != want.length) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: expected echo %02h last %b status %0d len %0d", $time,
                       want.echo, want.frame_end, want.status, want.length);
              $display("%0t:      got echo %02h last %b status %0d len %0d", $time,
                       m_data[7:0], m_last, m_user, m_data[15:8]);
            end
          end
        end
      end
      m_ready <= !receiver_stalls();
    end
  end

  // Watchdog: a long stretch with no beat on either side means the block hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int lim;
    int mn;
    int phase_start;
    frame_now = '0;
    limit_now = LONG_LIMIT_RESET;
    min_len_now = MIN_LENGTH_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset register values: a timeout with no frame
    // open, a good frame, a length mismatch and a frame one byte too short.
    push_item(ACT_TIMEOUT, 8'hFF);
    push_closed_frame(CH_S, CH_T, 8'd8, 1, 1'b0, 8'hFF);
    push_closed_frame(CH_S, CH_T, 8'd0, 1, 1'b0, 8'h80);
    push_closed_frame(CH_S, CH_T, 8'd7, 0, 1'b0, 8'h00);
    drain();

    // Random part: several register settings, extremes first.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin lim = 1; mn = 3; end
        1: begin lim = 255; mn = 255; end
        2: begin lim = 20; mn = 5; end
        3: begin lim = LONG_LIMIT_RESET; mn = MIN_LENGTH_RESET; end
        default: begin lim = $urandom_range(1, 255); mn = $urandom_range(3, 40); end
      endcase
      idle_mode = p / 2;
      write_reg(REG_LONG_LIMIT, 8'(lim));
      write_reg(REG_MIN_LENGTH, 8'(mn));
      phase_start = items_made;
      while (items_made - phase_start < PHASE_ITEMS) make_random_run();
      // A frame long enough for the count to saturate, declaring 255 bytes.
      if (p == 1) push_closed_frame(CH_S, CH_T, COUNT_MAX, 262, 1'b1, 8'h00);
      drain();
    end

    if (fail_count == 0 && expected_echoes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
